// File: rtl/dlt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlt_pkg
// Shared types and constants of the deduplicating error log table.
// ----------------------------------------------------------------------------
package dlt_pkg;

  localparam int unsigned DLT_ENTRIES = 16;
  localparam int unsigned DLT_ADDR_W  = 4;
  localparam int unsigned DLT_SLOT_W  = 4;
  localparam int unsigned DLT_IN_W    = 152;
  localparam int unsigned DLT_OUT_W   = 168;

  typedef enum logic [1:0] {
    MODE_LOG   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    STAT_IGNORED = 3'd0,
    STAT_MATCH   = 3'd1,
    STAT_FILL    = 3'd2,
    STAT_RING    = 3'd3,
    STAT_READ    = 3'd4,
    STAT_CLEAR   = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    REG_TYPE_COUNT    = 2'd0,
    REG_LEVEL_NONE    = 2'd1,
    REG_LEVEL_RECOVER = 2'd2,
    REG_COUNT_LIMIT   = 2'd3
  } reg_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_RING,
    S_READ,
    S_REPLY
  } state_e;

  typedef struct packed {
    logic [15:0] type_count;
    logic [15:0] level_none;
    logic [15:0] level_recover;
    logic [15:0] count_limit;
  } cfg_t;

  // One table entry, as held in the entry memory.
  typedef struct packed {
    logic [15:0] count;
    logic [31:0] value;
    logic [15:0] tag;
    logic [15:0] widget;
    logic [15:0] subcanvas;
    logic [15:0] canvas;
    logic [15:0] page;
    logic [15:0] level;
    logic [15:0] etype;
  } rec_t;

  localparam rec_t REC_RESET = '{
    count:     16'h0000,
    value:     32'hFFFF_FFFF,
    tag:       16'hFFFF,
    widget:    16'hFFFF,
    subcanvas: 16'hFFFF,
    canvas:    16'hFFFF,
    page:      16'hFFFF,
    level:     16'hFFFF,
    etype:     16'hFFFF
  };

endpackage

// File: rtl/dlt_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlt_cfg
// APB register file holding the four 16-bit configuration registers.
// ----------------------------------------------------------------------------
module dlt_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dlt_pkg::DLT_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output dlt_pkg::cfg_t                  cfg_o
);
  import dlt_pkg::*;

  cfg_t cfg_q, cfg_d;
  reg_e sel;
  logic wr;

  assign sel    = reg_e'(paddr[3:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (sel)
        REG_TYPE_COUNT:    cfg_d.type_count    = pwdata[15:0];
        REG_LEVEL_NONE:    cfg_d.level_none    = pwdata[15:0];
        REG_LEVEL_RECOVER: cfg_d.level_recover = pwdata[15:0];
        REG_COUNT_LIMIT:   cfg_d.count_limit   = pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      REG_TYPE_COUNT:    prdata = {16'h0000, cfg_q.type_count};
      REG_LEVEL_NONE:    prdata = {16'h0000, cfg_q.level_none};
      REG_LEVEL_RECOVER: prdata = {16'h0000, cfg_q.level_recover};
      REG_COUNT_LIMIT:   prdata = {16'h0000, cfg_q.count_limit};
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.type_count    <= 16'd64;
      cfg_q.level_none    <= 16'd0;
      cfg_q.level_recover <= 16'd4;
      cfg_q.count_limit   <= 16'hFFFF;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: rtl/dedup_error_log_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dedup_error_log_table
// Error log table that merges repeated errors, scanned through an entry memory.
// ----------------------------------------------------------------------------
// A log item reads the entries in order until one matches or is empty;
// when none takes it, the ring slot is fetched for its old count and overwritten.
// The scan reads one entry per cycle from the single-port entry memory while
// the output register is free. One item is worked at a time.
// Reset clears control state and the per-entry valid bits at once; an entry
// never written reads as its reset contents, so no clearing pass is needed.
module dedup_error_log_table #(
  parameter int unsigned ENTRIES = dlt_pkg::DLT_ENTRIES
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // s_tdata: error_type, error_level, page_id, canvas_id, subcanvas_id,
  // widget_id, tag_id, tag_value, read_index, zero pad (lowest bit first)
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [dlt_pkg::DLT_IN_W-1:0]   s_tdata,
  input  logic [1:0]                     s_tuser,   // mode
  // m_tdata: slot, entry_type, entry_level, entry_page, entry_canvas,
  // entry_subcanvas, entry_widget, entry_tag, entry_value, entry_count,
  // dirty, zero pad (lowest bit first)
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [dlt_pkg::DLT_OUT_W-1:0]  m_tdata,
  output logic [2:0]                     m_tuser,   // status
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [dlt_pkg::DLT_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);
  import dlt_pkg::*;

  localparam int unsigned IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  cfg_t cfg;

  dlt_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Incoming item fields.
  rec_t in_rec;
  logic [3:0] in_ridx;
  logic [IDX_W+3:0] in_ridx_wide;
  logic in_rd_ok;

  assign in_rec = '{
    count:     16'h0000,
    value:     s_tdata[143:112],
    tag:       s_tdata[111:96],
    widget:    s_tdata[95:80],
    subcanvas: s_tdata[79:64],
    canvas:    s_tdata[63:48],
    page:      s_tdata[47:32],
    level:     s_tdata[31:16],
    etype:     s_tdata[15:0]
  };
  assign in_ridx      = s_tdata[147:144];
  assign in_ridx_wide = {{IDX_W{1'b0}}, in_ridx};
  assign in_rd_ok     = in_ridx_wide < (IDX_W+4)'(ENTRIES);

  // Control and item registers.
  state_e state_q, state_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic [IDX_W-1:0] ring_q, ring_d;
  logic full_q, full_d;
  logic dirty_q, dirty_d;
  rec_t item_q;
  logic [3:0] rslot_q;
  logic rd_ok_q;
  status_e reply_q;

  // Entry memory with a registered read.
  rec_t mem [ENTRIES];
  logic [ENTRIES-1:0] vld_q;
  rec_t rdata_q;
  logic rvld_q;
  logic rd_en, wr_en;
  logic [IDX_W-1:0] rd_addr;
  rec_t cur, new_rec;

  // Output register.
  logic out_vld_q, out_load, out_free;
  status_e out_stat_d, out_stat_q;
  logic [3:0] out_slot_d, out_slot_q;
  rec_t out_rec_d, out_rec_q;
  logic out_dirty_q;

  logic hit_match, hit_empty, accept;
  logic [IDX_W-1:0] ring_p;
  logic [IDX_W+3:0] idx_wide;

  assign cur      = rvld_q ? rdata_q : REC_RESET;
  assign out_free = !out_vld_q || m_tready;
  assign s_tready = (state_q == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign idx_wide = {4'b0000, idx_q};

  always_comb begin
    new_rec       = item_q;
    new_rec.count = (cur.count < cfg.count_limit) ? cur.count + 16'd1 : cur.count;
  end

  assign hit_match = (cur.etype == item_q.etype) && (cur.level == item_q.level) &&
                     (cur.tag == item_q.tag) && (cur.page == item_q.page) &&
                     (cur.canvas == item_q.canvas) &&
                     (cur.subcanvas == item_q.subcanvas) &&
                     (cur.widget == item_q.widget);
  assign hit_empty = !full_q && ((cur.level <= cfg.level_none) ||
                                 (cur.level > cfg.level_recover));
  assign ring_p    = full_q ? ring_q : '0;

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    ring_d     = ring_q;
    full_d     = full_q;
    dirty_d    = dirty_q;
    rd_en      = 1'b0;
    rd_addr    = idx_q;
    wr_en      = 1'b0;
    out_load   = 1'b0;
    out_stat_d = reply_q;
    out_slot_d = '0;
    out_rec_d  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (s_tvalid) begin
          if (s_tuser == MODE_READ) begin
            rd_en   = 1'b1;
            rd_addr = in_rd_ok ? in_ridx_wide[IDX_W-1:0] : '0;
            state_d = S_READ;
          end else if (s_tuser == MODE_LOG &&
                       s_tdata[15:0] < cfg.type_count) begin
            rd_en   = 1'b1;
            rd_addr = '0;
            idx_d   = '0;
            state_d = S_SCAN;
          end else begin
            state_d = S_REPLY;
          end
        end
      end
      S_SCAN: begin
        if (out_free) begin
          if (hit_match || hit_empty) begin
            wr_en      = 1'b1;
            dirty_d    = 1'b1;
            out_load   = 1'b1;
            out_stat_d = hit_match ? STAT_MATCH : STAT_FILL;
            out_slot_d = idx_wide[3:0];
            out_rec_d  = new_rec;
            state_d    = S_IDLE;
          end else if (idx_q == LAST_IDX) begin
            // No entry took the item: fetch the ring slot for its old count.
            rd_en   = 1'b1;
            rd_addr = ring_p;
            idx_d   = ring_p;
            state_d = S_RING;
          end else begin
            rd_en   = 1'b1;
            rd_addr = idx_q + IDX_W'(1);
            idx_d   = idx_q + IDX_W'(1);
          end
        end
      end
      S_RING: begin
        if (out_free) begin
          wr_en      = 1'b1;
          dirty_d    = 1'b1;
          full_d     = 1'b1;
          ring_d     = (idx_q == LAST_IDX) ? '0 : idx_q + IDX_W'(1);
          out_load   = 1'b1;
          out_stat_d = STAT_RING;
          out_slot_d = idx_wide[3:0];
          out_rec_d  = new_rec;
          state_d    = S_IDLE;
        end
      end
      S_READ: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_stat_d = STAT_READ;
          out_slot_d = rslot_q;
          out_rec_d  = rd_ok_q ? cur : '0;
          state_d    = S_IDLE;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          out_load = 1'b1;
          if (reply_q == STAT_CLEAR) begin
            dirty_d = 1'b0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      ring_q    <= '0;
      full_q    <= 1'b0;
      dirty_q   <= 1'b0;
      vld_q     <= '0;
      rvld_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      ring_q  <= ring_d;
      full_q  <= full_d;
      dirty_q <= dirty_d;
      if (wr_en) begin
        vld_q[idx_q] <= 1'b1;
      end
      if (rd_en) begin
        rvld_q <= vld_q[rd_addr];
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (m_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Writes land before the next item's first read,
  // since a new item is only accepted once the previous one has finished.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[idx_q] <= new_rec;
    end
    if (rd_en) begin
      rdata_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q  <= in_rec;
      rslot_q <= in_ridx;
      rd_ok_q <= in_rd_ok;
      reply_q <= (s_tuser == MODE_CLEAR) ? STAT_CLEAR : STAT_IGNORED;
    end
    if (out_load) begin
      out_stat_q  <= out_stat_d;
      out_slot_q  <= out_slot_d;
      out_rec_q   <= out_rec_d;
      out_dirty_q <= dirty_d;
    end
  end

  assign m_tvalid = out_vld_q;
  assign m_tuser  = out_stat_q;
  assign m_tdata  = {3'b000, out_dirty_q, out_rec_q.count, out_rec_q.value,
                     out_rec_q.tag, out_rec_q.widget, out_rec_q.subcanvas,
                     out_rec_q.canvas, out_rec_q.page, out_rec_q.level,
                     out_rec_q.etype, out_slot_q};

  a_ring_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ring_q <= LAST_IDX)
    else $error("ring pointer beyond last entry");

  a_full_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_q |=> full_q)
    else $error("table full flag dropped");

  a_write_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> ((state_q == S_SCAN || state_q == S_RING) && out_free))
    else $error("entry write outside a log decision");

  a_write_reply: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (m_tvalid && out_dirty_q && state_q == S_IDLE))
    else $error("entry write without a dirty result");

  a_ring_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RING && out_free) |=> full_q)
    else $error("ring overwrite did not mark table full");

endmodule

// File: bench/tb_dedup_error_log_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dedup_error_log_table
// Self-checking bench for the deduplicating error log table. Log, read, clear
// and unused-mode items are streamed in with random gaps, and every entry
// report is compared field by field against a table model kept in the bench.
// The configuration is reprogrammed between phases through the APB port.
// ----------------------------------------------------------------------------
module tb_dedup_error_log_table;
  import dlt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned LONG_STALL  = 300;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  mode;
    logic [15:0] etype;
    logic [15:0] level;
    logic [15:0] page;
    logic [15:0] canvas;
    logic [15:0] subcanvas;
    logic [15:0] widget;
    logic [15:0] tag;
    logic [31:0] value;
    logic [3:0]  rd_index;
  } log_item_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  slot;
    rec_t        rec;
    logic        dirty;
  } entry_report_t;

  logic clk_i;
  logic rst_ni;
  logic s_tvalid;
  logic s_tready;
  logic [DLT_IN_W-1:0] s_tdata;
  logic [1:0] s_tuser;
  logic m_tvalid;
  logic m_tready;
  logic [DLT_OUT_W-1:0] m_tdata;
  logic [2:0] m_tuser;
  logic psel;
  logic penable;
  logic pwrite;
  logic [DLT_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  dedup_error_log_table uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Table model state.
  rec_t        tbl [DLT_ENTRIES];
  logic        tbl_full;
  int unsigned ring_ptr;
  logic        dirty_flag;
  cfg_t        cfg;

  log_item_t     log_requests_q [$];
  entry_report_t entry_reports_q [$];
  log_item_t     key_pool [$];
  log_item_t     offer;

  logic        in_taken;
  logic        out_taken;
  int unsigned tx_gap;
  bit          tx_calm;
  int unsigned rx_wait;
  bit          rx_calm;
  int unsigned results_seen;
  int unsigned err_cnt;
  int unsigned cycles;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic bit is_vacant(int unsigned i);
    return tbl[i].level <= cfg.level_none || tbl[i].level > cfg.level_recover;
  endfunction

  function automatic bit key_hit(int unsigned i, log_item_t it);
    return tbl[i].etype == it.etype && tbl[i].level == it.level &&
           tbl[i].tag == it.tag && tbl[i].page == it.page &&
           tbl[i].canvas == it.canvas && tbl[i].subcanvas == it.subcanvas &&
           tbl[i].widget == it.widget;
  endfunction

  // Stores the key and value in entry i and bumps its count, which holds at
  // the limit and is left alone if it already sits above it.
  function automatic void store_entry(int unsigned i, log_item_t it);
    tbl[i].etype     = it.etype;
    tbl[i].level     = it.level;
    tbl[i].tag       = it.tag;
    tbl[i].page      = it.page;
    tbl[i].canvas    = it.canvas;
    tbl[i].subcanvas = it.subcanvas;
    tbl[i].widget    = it.widget;
    tbl[i].value     = it.value;
    if (tbl[i].count < cfg.count_limit) tbl[i].count = tbl[i].count + 16'd1;
    dirty_flag = 1'b1;
  endfunction

  function automatic entry_report_t table_apply(log_item_t it);
    entry_report_t r;
    int unsigned   i;
    int unsigned   p;
    bit            done;
    r = '0;
    done = 1'b0;
    if (it.mode == MODE_READ) begin
      r.status = STAT_READ;
      r.slot = it.rd_index;
      r.rec = tbl[it.rd_index];
    end else if (it.mode == MODE_CLEAR) begin
      dirty_flag = 1'b0;
      r.status = STAT_CLEAR;
    end else if (it.mode != MODE_LOG || it.etype >= cfg.type_count) begin
      r.status = STAT_IGNORED;
    end else begin
      for (i = 0; i < DLT_ENTRIES; i++) begin
        if (!done && key_hit(i, it)) begin
          store_entry(i, it);
          r.status = STAT_MATCH;
          r.slot = 4'(i);
          r.rec = tbl[i];
          done = 1'b1;
        end else if (!done && !tbl_full && is_vacant(i)) begin
          store_entry(i, it);
          r.status = STAT_FILL;
          r.slot = 4'(i);
          r.rec = tbl[i];
          done = 1'b1;
        end
      end
      if (!done) begin
        if (!tbl_full) begin
          tbl_full = 1'b1;
          ring_ptr = 0;
        end
        p = ring_ptr;
        store_entry(p, it);
        ring_ptr = (p + 1 >= DLT_ENTRIES) ? 0 : p + 1;
        r.status = STAT_RING;
        r.slot = 4'(p);
        r.rec = tbl[p];
      end
    end
    r.dirty = dirty_flag;
    return r;
  endfunction

  task automatic chk_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // Sender: one item per handshake, with a random gap before each new item.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_tvalid || in_taken)) begin
      if (in_taken) begin
        if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
        tx_gap = tx_calm ? 0 : $urandom_range(0, 7);
      end
      if (tx_gap != 0) begin
        tx_gap--;
        s_tvalid <= 1'b0;
      end else if (log_requests_q.size() != 0) begin
        offer = log_requests_q.pop_front();
        s_tdata <= {4'b0, offer.rd_index, offer.value, offer.tag, offer.widget,
                    offer.subcanvas, offer.canvas, offer.page, offer.level, offer.etype};
        s_tuser <= offer.mode;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stall per item, plus two long stretches that back the
  // block up while the sender keeps offering.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_taken) begin
        if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
        rx_wait = rx_calm ? 0 : $urandom_range(0, 7);
        if (results_seen == 400 || results_seen == 900) rx_wait = LONG_STALL;
      end
      if (rx_wait != 0) begin
        rx_wait--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    entry_report_t want;
    in_taken  <= rst_ni && s_tvalid && s_tready;
    out_taken <= rst_ni && m_tvalid && m_tready;
    if (rst_ni && m_tvalid && m_tready) begin
      results_seen++;
      if (entry_reports_q.size() == 0) begin
        $display("%0t: unexpected item, expected none, got status %0h data %0h",
                 $time, m_tuser, m_tdata);
        err_cnt++;
      end else begin
        want = entry_reports_q.pop_front();
        chk_field("status", 32'(want.status), 32'(m_tuser));
        chk_field("slot", 32'(want.slot), 32'(m_tdata[3:0]));
        chk_field("entry_type", 32'(want.rec.etype), 32'(m_tdata[19:4]));
        chk_field("entry_level", 32'(want.rec.level), 32'(m_tdata[35:20]));
        chk_field("entry_page", 32'(want.rec.page), 32'(m_tdata[51:36]));
        chk_field("entry_canvas", 32'(want.rec.canvas), 32'(m_tdata[67:52]));
        chk_field("entry_subcanvas", 32'(want.rec.subcanvas), 32'(m_tdata[83:68]));
        chk_field("entry_widget", 32'(want.rec.widget), 32'(m_tdata[99:84]));
        chk_field("entry_tag", 32'(want.rec.tag), 32'(m_tdata[115:100]));
        chk_field("entry_value", want.rec.value, m_tdata[147:116]);
        chk_field("entry_count", 32'(want.rec.count), 32'(m_tdata[163:148]));
        chk_field("dirty", 32'(want.dirty), 32'(m_tdata[164]));
      end
    end
    if (rst_ni && s_tvalid && s_tready) entry_reports_q.push_back(table_apply(offer));
  end

  function automatic log_item_t random_fields();
    log_item_t it;
    it.mode      = MODE_LOG;
    it.etype     = 16'($urandom);
    it.level     = 16'($urandom);
    it.page      = 16'($urandom);
    it.canvas    = 16'($urandom);
    it.subcanvas = 16'($urandom);
    it.widget    = 16'($urandom);
    it.tag       = 16'($urandom);
    it.value     = $urandom;
    it.rd_index  = 4'($urandom);
    return it;
  endfunction

  function automatic log_item_t mk(logic [1:0] mode, logic [15:0] etype, logic [15:0] level,
                                   logic [15:0] ids, logic [31:0] value, logic [3:0] idx);
    log_item_t it;
    it.mode = mode;
    it.etype = etype;
    it.level = level;
    it.page = ids;
    it.canvas = ids;
    it.subcanvas = ids;
    it.widget = ids;
    it.tag = ids;
    it.value = value;
    it.rd_index = idx;
    return it;
  endfunction

  // Pool keys use a valid type and, where the level window allows, a level
  // that marks the entry as occupied, so repeats merge into one entry.
  task automatic build_pool(int unsigned n);
    log_item_t it;
    key_pool.delete();
    repeat (n) begin
      it = random_fields();
      it.etype = 16'($urandom_range(0, cfg.type_count - 1));
      if (cfg.level_recover > cfg.level_none)
        it.level = 16'($urandom_range(cfg.level_none + 1, cfg.level_recover));
      key_pool.push_back(it);
    end
  endtask

  task automatic queue_random(int unsigned n);
    log_item_t   it;
    int unsigned pick;
    repeat (n) begin
      pick = $urandom_range(0, 99);
      it = random_fields();
      if (pick < 68) begin
        it = key_pool[$urandom_range(0, key_pool.size() - 1)];
        it.value = $urandom;
        it.rd_index = 4'($urandom);
      end else if (pick < 78) begin
        if ($urandom_range(0, 1) == 0)
          it.etype = 16'($urandom_range(0, cfg.type_count - 1));
      end else if (pick < 90) begin
        it.mode = MODE_READ;
      end else if (pick < 96) begin
        it.mode = MODE_CLEAR;
      end else begin
        it.mode = MODE_UNUSED;
      end
      log_requests_q.push_back(it);
    end
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk_i);
      #1;
    end while (log_requests_q.size() != 0 || s_tvalid || entry_reports_q.size() != 0);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic reg_write(reg_e r, logic [15:0] v);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= 32'(v);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (r)
      REG_TYPE_COUNT:    cfg.type_count    = v;
      REG_LEVEL_NONE:    cfg.level_none    = v;
      REG_LEVEL_RECOVER: cfg.level_recover = v;
      REG_COUNT_LIMIT:   cfg.count_limit   = v;
      default: ;
    endcase
  endtask

  // The sender pauses halfway until every report of the first half is back.
  task automatic run_phase(logic [15:0] tc, logic [15:0] ln, logic [15:0] lr,
                           logic [15:0] cl, int unsigned n, int unsigned pool_n);
    wait_idle();
    reg_write(REG_TYPE_COUNT, tc);
    reg_write(REG_LEVEL_NONE, ln);
    reg_write(REG_LEVEL_RECOVER, lr);
    reg_write(REG_COUNT_LIMIT, cl);
    @(posedge clk_i);
    if (pool_n != 0) build_pool(pool_n);
    queue_random(n / 2);
    wait_idle();
    queue_random(n - n / 2);
  endtask

  initial begin
    rst_ni   = 1'b0;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = MODE_LOG;
    m_tready = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    in_taken = 1'b0;
    out_taken = 1'b0;
    tx_gap = 0;
    rx_wait = 0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    results_seen = 0;
    err_cnt = 0;
    cycles = 0;
    for (int i = 0; i < DLT_ENTRIES; i++) tbl[i] = REC_RESET;
    tbl_full = 1'b0;
    ring_ptr = 0;
    dirty_flag = 1'b0;
    cfg.type_count = 16'd64;
    cfg.level_none = 16'd0;
    cfg.level_recover = 16'd4;
    cfg.count_limit = 16'hFFFF;

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset configuration.
    log_requests_q.push_back(mk(MODE_CLEAR, 16'h0, 16'h0, 16'h0, 32'h0, 4'd0));
    log_requests_q.push_back(mk(MODE_READ, 16'h0, 16'h0, 16'h0, 32'h0, 4'd0));
    log_requests_q.push_back(mk(MODE_READ, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 4'd15));
    log_requests_q.push_back(mk(MODE_UNUSED, 16'h1, 16'h1, 16'hFFFF, 32'hFFFFFFFF, 4'd15));
    log_requests_q.push_back(mk(MODE_LOG, 16'hFFFF, 16'd1, 16'h0, 32'h0, 4'd0));
    log_requests_q.push_back(mk(MODE_LOG, 16'd64, 16'd2, 16'h1, 32'h1, 4'd0));
    log_requests_q.push_back(mk(MODE_LOG, 16'd63, 16'd4, 16'hFFFF, 32'hFFFFFFFF, 4'd0));
    log_requests_q.push_back(mk(MODE_LOG, 16'd63, 16'd4, 16'hFFFF, 32'h0, 4'd0));
    log_requests_q.push_back(mk(MODE_LOG, 16'd0, 16'd1, 16'h0, 32'h0, 4'd0));
    // A level of zero leaves the entry empty; the repeat still merges into
    // it since a matching key wins over an empty entry.
    log_requests_q.push_back(mk(MODE_LOG, 16'd5, 16'd0, 16'h1234, 32'hAAAA5555, 4'd0));
    log_requests_q.push_back(mk(MODE_LOG, 16'd5, 16'd0, 16'h1234, 32'h5555AAAA, 4'd0));
    // A level above the recover level also counts as empty, so the next
    // valid log refills the same entry and keeps counting up.
    log_requests_q.push_back(mk(MODE_LOG, 16'd6, 16'd5, 16'h5555, 32'h0F0F0F0F, 4'd0));
    log_requests_q.push_back(mk(MODE_READ, 16'h0, 16'h0, 16'h0, 32'h0, 4'd2));
    log_requests_q.push_back(mk(MODE_LOG, 16'd7, 16'd3, 16'hA5A5, 32'hF0F0F0F0, 4'd0));
    log_requests_q.push_back(mk(MODE_READ, 16'h0, 16'h0, 16'h0, 32'h0, 4'd1));
    log_requests_q.push_back(mk(MODE_CLEAR, 16'h0, 16'h0, 16'h0, 32'h0, 4'd0));
    log_requests_q.push_back(mk(MODE_READ, 16'h0, 16'h0, 16'h0, 32'h0, 4'd3));
    log_requests_q.push_back(mk(MODE_LOG, 16'd0, 16'd1, 16'h0, 32'h12345678, 4'd0));

    // Narrowed level window turns some directed entries empty again.
    run_phase(16'd64, 16'd2, 16'd3, 16'hFFFF, 230, 24);
    run_phase(16'hFFFF, 16'd0, 16'hFFFF, 16'd3, 220, 12);
    run_phase(16'd1, 16'hFFFF, 16'd0, 16'd1, 200, 6);
    run_phase(16'd1000, 16'd100, 16'd200, 16'hFFFF, 220, 4);
    // Same keys with a lower limit: counts already above it stay put.
    run_phase(16'hFFFF, 16'd0, 16'hFFFF, 16'd2, 220, 0);
    run_phase(16'd300, 16'd0, 16'd0, 16'hFFFF, 220, 30);
    wait_idle();

    if (err_cnt == 0 && entry_reports_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/dlt_pkg.sv
rtl/dlt_cfg.sv
rtl/dedup_error_log_table.sv
bench/tb_dedup_error_log_table.sv
